[hdl/sbe_pkg.sv]
// Shared types, opcodes and constants of the stack bytecode executor.
package sbe_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;

  localparam logic [7:0] OP_STATUS = 8'h00;
  localparam logic [7:0] OP_INPUT  = 8'h01;
  localparam logic [7:0] OP_RANDOM = 8'h02;
  localparam logic [7:0] OP_TIME   = 8'h05;
  localparam logic [7:0] OP_PLAY   = 8'h0A;
  localparam logic [7:0] OP_DROP   = 8'h20;
  localparam logic [7:0] OP_DUP    = 8'h21;
  localparam logic [7:0] OP_PUSH   = 8'h22;
  localparam logic [7:0] OP_SWAP   = 8'h23;
  localparam logic [7:0] OP_ROT    = 8'h24;
  localparam logic [7:0] OP_OVER   = 8'h25;
  localparam logic [7:0] OP_LOAD   = 8'h26;
  localparam logic [7:0] OP_LOADN  = 8'h27;
  localparam logic [7:0] OP_STOR   = 8'h28;
  localparam logic [7:0] OP_STORN  = 8'h29;
  localparam logic [7:0] OP_ADD    = 8'h30;
  localparam logic [7:0] OP_SUB    = 8'h31;
  localparam logic [7:0] OP_MUL    = 8'h32;
  localparam logic [7:0] OP_DIV    = 8'h33;
  localparam logic [7:0] OP_AND    = 8'h35;
  localparam logic [7:0] OP_OR     = 8'h36;
  localparam logic [7:0] OP_XOR    = 8'h37;
  localparam logic [7:0] OP_NOT    = 8'h38;
  localparam logic [7:0] OP_LNOT   = 8'h3A;
  localparam logic [7:0] OP_LAND   = 8'h3B;
  localparam logic [7:0] OP_CALL   = 8'h70;
  localparam logic [7:0] OP_RET    = 8'h71;
  localparam logic [7:0] OP_JMP    = 8'h80;
  localparam logic [7:0] OP_JEQ    = 8'h81;
  localparam logic [7:0] OP_JGE    = 8'h86;
  localparam logic [7:0] OP_JREL   = 8'h90;
  localparam logic [7:0] OP_RJEQ   = 8'h91;
  localparam logic [7:0] OP_RJGE   = 8'h96;

  localparam logic [7:0] CMP_MASK = 8'h07;
  localparam logic [2:0] CMP_EQ = 3'd1;
  localparam logic [2:0] CMP_NE = 3'd2;
  localparam logic [2:0] CMP_LT = 3'd3;
  localparam logic [2:0] CMP_LE = 3'd4;
  localparam logic [2:0] CMP_GT = 3'd5;
  localparam logic [2:0] CMP_GE = 3'd6;

  localparam logic [15:0] DIV_ZERO_Q = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] operand_word;
    logic [15:0] second_word;
    logic        audio_busy;
    logic [7:0]  input_lines;
    logic [15:0] time_ms;
    logic [15:0] random_value;
  } in_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        play_request;
    logic [15:0] play_asset;
    logic [15:0] top_value;
    logic        stack_error;
  } out_t;

  // Instruction length in bytes by opcode
  function automatic logic [2:0] op_len(input logic [7:0] op);
    logic [2:0] len;
    len = 3'd1;
    if (op == OP_RANDOM) len = 3'd5;
    else if (op == OP_LOADN || op == OP_STORN) len = 3'd2;
    else if (op == OP_PUSH || op == OP_CALL || op == OP_JMP || op == OP_JREL) len = 3'd3;
    else if (op inside {[OP_JEQ:OP_JGE], [OP_RJEQ:OP_RJGE]}) len = 3'd3;
    return len;
  endfunction

endpackage

[hdl/stack_bytecode_executor_top.sv]
// Stack bytecode executor: sequencer around the stack RAM and the divider.
//
// One input transaction carries one instruction (opcode, operand bytes) plus
// the sampled status inputs; one output transaction returns the next fetch
// address, a play request, the top of stack and a stack error flag.
// Items are executed one at a time: in_ready is high only while the
// sequencer waits for an instruction.
// Sequencing, set by the single read port of the stack RAM: four operand
// reads, an execute step, up to three write-backs and a top-of-stack read,
// one RAM access per step; a divide by a nonzero divisor also waits for
// the bit-serial divider.
// Reset: program counter and stack pointer clear, every stack entry reads
// as zero through per-entry valid bits; no clearing pass is needed.
// Stall: a result waits in the output register; the next instruction may be
// accepted meanwhile, and its result holds back until the register frees.
module stack_bytecode_executor_top import sbe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_MAX  = SPW'(STACK_DEPTH);
  localparam logic [15:0]    IDX_MAX = 16'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_RC, S_RX, S_RXW, S_DIV, S_EXEC,
    S_W0, S_W1, S_W2, S_TOP, S_TOPC
  } state_t;

  state_t         state_r;
  in_t            it_r;
  logic [15:0]    pc_r;
  logic [SPW-1:0] sp_r;
  logic [15:0]    a_r, b_r, c_r, x_r;
  logic [2:0]     wen_r;
  logic [AW-1:0]  wadr_r [3];
  logic [15:0]    wdat_r [3];
  logic           play_r, err_r;
  logic [15:0]    asset_r;
  logic           out_valid_r;
  out_t           out_r;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [15:0]    mem_wdata, mem_rdata;
  logic           div_start, div_done;
  logic [15:0]    div_q;

  // Map a stack position to a RAM index, parking anything out of range at zero
  function automatic logic [AW-1:0] sp_idx(input logic [SPW-1:0] v);
    return (v < SP_MAX) ? v[AW-1:0] : '0;
  endfunction

  function automatic logic [AW-1:0] val_idx(input logic [15:0] v);
    return (v < IDX_MAX) ? v[AW-1:0] : '0;
  endfunction

  sbe_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sbe_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (b_r),
    .divisor  (a_r),
    .done     (div_done),
    .quotient (div_q)
  );

  logic [15:0] nidx;
  assign nidx = {8'h00, it_r.operand_word[15:8]};

  // Select the read address for each sequencing step
  always_comb begin
    case (state_r)
      S_RA:          mem_raddr = sp_idx(sp_r - SPW'(1));
      S_RB:          mem_raddr = sp_idx(sp_r - SPW'(2));
      S_RC:          mem_raddr = sp_idx(sp_r - SPW'(3));
      S_RX:          mem_raddr = (it_r.opcode == OP_LOAD) ? val_idx(a_r) : val_idx(nidx);
      S_TOP, S_TOPC: mem_raddr = sp_idx(sp_r - SPW'(1));
      default:       mem_raddr = '0;
    endcase
  end

  // Drive one queued write-back per write state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wadr_r[0];
    mem_wdata = wdat_r[0];
    case (state_r)
      S_W0: begin
        mem_we = wen_r[0]; mem_waddr = wadr_r[0]; mem_wdata = wdat_r[0];
      end
      S_W1: begin
        mem_we = wen_r[1]; mem_waddr = wadr_r[1]; mem_wdata = wdat_r[1];
      end
      S_W2: begin
        mem_we = wen_r[2]; mem_waddr = wadr_r[2]; mem_wdata = wdat_r[2];
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == S_RXW) && (it_r.opcode == OP_DIV) && (a_r != '0);

  // Execute the instruction on the fetched operands
  logic [15:0]    after, npc, asset, alu;
  logic [31:0]    prod;
  logic [SPW-1:0] nsp;
  logic           err, play, ok1, ok2, ok3, room, cond;
  logic [2:0]     we;
  logic [AW-1:0]  wa [3];
  logic [15:0]    wd [3];

  always_comb begin
    after = pc_r + 16'(op_len(it_r.opcode));
    npc   = after;
    nsp   = sp_r;
    err   = 1'b0;
    play  = 1'b0;
    asset = '0;
    we    = '0;
    for (int i = 0; i < 3; i++) begin
      wa[i] = '0;
      wd[i] = '0;
    end
    ok1  = sp_r >= SPW'(1);
    ok2  = sp_r >= SPW'(2);
    ok3  = sp_r >= SPW'(3);
    room = sp_r < SP_MAX;
    prod = a_r * b_r;
    case (it_r.opcode)
      OP_ADD:  alu = b_r + a_r;
      OP_SUB:  alu = b_r - a_r;
      OP_MUL:  alu = prod[15:0];
      OP_DIV:  alu = (a_r == '0) ? DIV_ZERO_Q : div_q;
      OP_AND:  alu = b_r & a_r;
      OP_OR:   alu = b_r | a_r;
      OP_XOR:  alu = b_r ^ a_r;
      default: alu = {15'd0, (b_r != '0) && (a_r != '0)};
    endcase
    case (3'(it_r.opcode & CMP_MASK))
      CMP_EQ:  cond = a_r == b_r;
      CMP_NE:  cond = a_r != b_r;
      CMP_LT:  cond = a_r < b_r;
      CMP_LE:  cond = a_r <= b_r;
      CMP_GT:  cond = a_r > b_r;
      CMP_GE:  cond = a_r >= b_r;
      default: cond = 1'b0;
    endcase
    case (it_r.opcode)
      OP_STATUS, OP_INPUT, OP_RANDOM, OP_TIME, OP_PUSH, OP_CALL: begin
        if (room) begin
          we[0] = 1'b1;
          wa[0] = sp_idx(sp_r);
          nsp   = sp_r + SPW'(1);
          case (it_r.opcode)
            OP_STATUS: wd[0] = {15'd0, it_r.audio_busy};
            OP_INPUT:  wd[0] = {8'd0, it_r.input_lines};
            OP_RANDOM: wd[0] = it_r.random_value;
            OP_TIME:   wd[0] = it_r.time_ms;
            OP_PUSH:   wd[0] = it_r.operand_word;
            default: begin
              wd[0] = after;
              npc   = it_r.operand_word;
            end
          endcase
        end else err = 1'b1;
      end
      OP_PLAY: begin
        if (ok1) begin
          asset = a_r; play = 1'b1; nsp = sp_r - SPW'(1);
        end else err = 1'b1;
      end
      OP_DROP: begin
        if (ok1) nsp = sp_r - SPW'(1); else err = 1'b1;
      end
      OP_DUP, OP_OVER: begin
        if ((it_r.opcode == OP_DUP ? ok1 : ok2) && room) begin
          we[0] = 1'b1; wa[0] = sp_idx(sp_r);
          wd[0] = (it_r.opcode == OP_DUP) ? a_r : b_r;
          nsp   = sp_r + SPW'(1);
        end else err = 1'b1;
      end
      OP_SWAP: begin
        if (ok2) begin
          we = 3'b011;
          wa[0] = sp_idx(sp_r - SPW'(1)); wd[0] = b_r;
          wa[1] = sp_idx(sp_r - SPW'(2)); wd[1] = a_r;
        end else err = 1'b1;
      end
      OP_ROT: begin
        if (ok3) begin
          we = 3'b111;
          wa[0] = sp_idx(sp_r - SPW'(2)); wd[0] = c_r;
          wa[1] = sp_idx(sp_r - SPW'(3)); wd[1] = a_r;
          wa[2] = sp_idx(sp_r - SPW'(1)); wd[2] = b_r;
        end else err = 1'b1;
      end
      OP_LOAD: begin
        if (ok1 && a_r < IDX_MAX) begin
          we[0] = 1'b1; wa[0] = sp_idx(sp_r - SPW'(1)); wd[0] = x_r;
        end else err = 1'b1;
      end
      OP_LOADN: begin
        if (room && nidx < IDX_MAX) begin
          we[0] = 1'b1; wa[0] = sp_idx(sp_r); wd[0] = x_r;
          nsp   = sp_r + SPW'(1);
        end else err = 1'b1;
      end
      OP_STOR: begin
        if (ok2 && b_r < IDX_MAX) begin
          we[0] = 1'b1; wa[0] = val_idx(b_r); wd[0] = a_r;
          nsp   = sp_r - SPW'(2);
        end else err = 1'b1;
      end
      OP_STORN: begin
        if (ok1 && nidx < IDX_MAX) begin
          we[0] = 1'b1; wa[0] = val_idx(nidx); wd[0] = a_r;
          nsp   = sp_r - SPW'(1);
        end else err = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_LAND: begin
        if (ok2) begin
          we[0] = 1'b1; wa[0] = sp_idx(sp_r - SPW'(2)); wd[0] = alu;
          nsp   = sp_r - SPW'(1);
        end else err = 1'b1;
      end
      OP_NOT, OP_LNOT: begin
        if (ok1) begin
          we[0] = 1'b1; wa[0] = sp_idx(sp_r - SPW'(1));
          wd[0] = (it_r.opcode == OP_NOT) ? ~a_r : {15'd0, a_r == '0};
        end else err = 1'b1;
      end
      OP_RET: begin
        if (ok1) begin
          npc = a_r; nsp = sp_r - SPW'(1);
        end else err = 1'b1;
      end
      OP_JMP:  npc = it_r.operand_word;
      OP_JREL: npc = after + it_r.operand_word;
      default: begin
        if (it_r.opcode inside {[OP_JEQ:OP_JGE], [OP_RJEQ:OP_RJGE]}) begin
          if (ok2) begin
            nsp = sp_r - SPW'(2);
            if (cond) begin
              npc = (it_r.opcode < OP_JREL) ? it_r.operand_word
                                            : after + it_r.operand_word;
            end
          end else err = 1'b1;
        end
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer: state, architectural registers and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      wen_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_TOPC) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            it_r    <= in_data;
            state_r <= S_RA;
          end
        end
        S_RA:  state_r <= S_RB;
        S_RB: begin
          a_r <= mem_rdata; state_r <= S_RC;
        end
        S_RC: begin
          b_r <= mem_rdata; state_r <= S_RX;
        end
        S_RX: begin
          c_r <= mem_rdata; state_r <= S_RXW;
        end
        S_RXW: begin
          x_r     <= mem_rdata;
          state_r <= div_start ? S_DIV : S_EXEC;
        end
        S_DIV: if (div_done) state_r <= S_EXEC;
        S_EXEC: begin
          wen_r   <= we;
          wadr_r  <= wa;
          wdat_r  <= wd;
          pc_r    <= npc;
          sp_r    <= nsp;
          play_r  <= play;
          asset_r <= asset;
          err_r   <= err;
          state_r <= S_W0;
        end
        S_W0:  state_r <= S_W1;
        S_W1:  state_r <= S_W2;
        S_W2:  state_r <= S_TOP;
        S_TOP: state_r <= S_TOPC;
        S_TOPC: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r        <= 1'b1;
            out_r.next_pc      <= pc_r;
            out_r.play_request <= play_r;
            out_r.play_asset   <= asset_r;
            out_r.top_value    <= (sp_r != '0) ? mem_rdata : '0;
            out_r.stack_error  <= err_r;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/sbe_stack_mem.sv]
// Stack store: synchronous RAM with per-entry valid bits that read as zero after reset.
module sbe_stack_mem import sbe_pkg::*; #(
  parameter int unsigned DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;
  logic [15:0]      rd_q_r;

  // Track written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      rd_vld_r <= vld_r[raddr];
    end
  end

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q_r <= mem[raddr];
  end

  assign rdata = rd_vld_r ? rd_q_r : '0;

endmodule

[hdl/sbe_divider.sv]
// Restoring 16-bit divider, one quotient bit per cycle.
module sbe_divider import sbe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic        run_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [15:0] q_r;
  logic [15:0] rem_r;
  logic [15:0] dvs_r;
  logic [16:0] trial;
  logic        qbit;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_r, q_r[15]};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'd16;
      end else if (run_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      q_r   <= {q_r[14:0], qbit};
      rem_r <= qbit ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[hdl/sbe_checker.sv]
// Port-level checks of the stack bytecode executor and their binding.
module sbe_checker import sbe_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // One instruction in flight: no acceptance right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second instruction accepted while one is executing");

  // A skipped step never plays
  a_err_no_play: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.stack_error && out_data.play_request))
    else $error("play issued on a stack error");

  // Asset is zero without a request
  a_asset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.play_request |-> out_data.play_asset == '0)
    else $error("asset index without play request");

endmodule

bind stack_bytecode_executor_top sbe_checker u_sbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[dv/stack_bytecode_executor_top_tb.sv]
// Self-checking testbench of the stack bytecode executor with its own instruction predictor.
`timescale 1ns / 1ps

module stack_bytecode_executor_top_tb;
  import sbe_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // sender idle and receiver stall percentages, hold-off length
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // predictor copy of the machine
  logic [15:0] pc_model;
  int          sp_model;
  logic [15:0] stack_model [DEPTH];
  out_t        pending_results [$];

  stack_bytecode_executor_top #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [15:0] instr_length(input logic [7:0] op);
    if (op == OP_RANDOM) return 16'd5;
    if (op == OP_LOADN || op == OP_STORN) return 16'd2;
    if (op == OP_PUSH || op == OP_CALL || op == OP_JMP || op == OP_JREL) return 16'd3;
    if ((op >= OP_JEQ && op <= OP_JGE) || (op >= OP_RJEQ && op <= OP_RJGE)) return 16'd3;
    return 16'd1;
  endfunction

  function automatic bit compare_holds(input logic [2:0] kind, input logic [15:0] a,
                                       input logic [15:0] b);
    case (kind)
      CMP_EQ: return a == b;
      CMP_NE: return a != b;
      CMP_LT: return a < b;
      CMP_LE: return a <= b;
      CMP_GT: return a > b;
      CMP_GE: return a >= b;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit room(input int need, input int grow);
    return sp_model >= need && sp_model + grow <= DEPTH;
  endfunction

  // compute the expected result of one instruction and advance the model
  function automatic out_t execute_instr(input in_t it);
    out_t r;
    logic [15:0] after, npc, a, b, w;
    int nidx;
    bit err;
    r = '0;
    w = it.operand_word;
    nidx = int'(w[15:8]);
    after = pc_model + instr_length(it.opcode);
    npc = after;
    err = 1'b0;
    case (it.opcode)
      OP_STATUS, OP_INPUT, OP_RANDOM, OP_TIME, OP_PUSH: begin
        if (room(0, 1)) begin
          case (it.opcode)
            OP_STATUS: a = {15'd0, it.audio_busy};
            OP_INPUT:  a = {8'd0, it.input_lines};
            OP_RANDOM: a = it.random_value;
            OP_TIME:   a = it.time_ms;
            default:   a = w;
          endcase
          stack_model[sp_model] = a;
          sp_model++;
        end else err = 1'b1;
      end
      OP_PLAY: begin
        if (room(1, 0)) begin
          sp_model--;
          r.play_asset = stack_model[sp_model];
          r.play_request = 1'b1;
        end else err = 1'b1;
      end
      OP_DROP: if (room(1, 0)) sp_model--; else err = 1'b1;
      OP_DUP: begin
        if (room(1, 1)) begin
          stack_model[sp_model] = stack_model[sp_model-1];
          sp_model++;
        end else err = 1'b1;
      end
      OP_OVER: begin
        if (room(2, 1)) begin
          stack_model[sp_model] = stack_model[sp_model-2];
          sp_model++;
        end else err = 1'b1;
      end
      OP_SWAP: begin
        if (room(2, 0)) begin
          a = stack_model[sp_model-1];
          stack_model[sp_model-1] = stack_model[sp_model-2];
          stack_model[sp_model-2] = a;
        end else err = 1'b1;
      end
      OP_ROT: begin
        if (room(3, 0)) begin
          a = stack_model[sp_model-1];
          b = stack_model[sp_model-2];
          stack_model[sp_model-2] = stack_model[sp_model-3];
          stack_model[sp_model-3] = a;
          stack_model[sp_model-1] = b;
        end else err = 1'b1;
      end
      OP_LOAD: begin
        if (room(1, 0) && stack_model[sp_model-1] < DEPTH)
          stack_model[sp_model-1] = stack_model[stack_model[sp_model-1]];
        else err = 1'b1;
      end
      OP_LOADN: begin
        if (room(0, 1) && nidx < DEPTH) begin
          stack_model[sp_model] = stack_model[nidx];
          sp_model++;
        end else err = 1'b1;
      end
      OP_STOR: begin
        if (room(2, 0) && stack_model[sp_model-2] < DEPTH) begin
          a = stack_model[sp_model-1];
          b = stack_model[sp_model-2];
          sp_model -= 2;
          stack_model[b] = a;
        end else err = 1'b1;
      end
      OP_STORN: begin
        if (room(1, 0) && nidx < DEPTH) begin
          sp_model--;
          stack_model[nidx] = stack_model[sp_model];
        end else err = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_LAND: begin
        if (room(2, 0)) begin
          a = stack_model[sp_model-1];
          b = stack_model[sp_model-2];
          case (it.opcode)
            OP_ADD: b = b + a;
            OP_SUB: b = b - a;
            OP_MUL: b = b * a;
            OP_DIV: b = (a == 0) ? DIV_ZERO_Q : b / a;
            OP_AND: b = b & a;
            OP_OR:  b = b | a;
            OP_XOR: b = b ^ a;
            default: b = (b != 0 && a != 0) ? 16'd1 : 16'd0;
          endcase
          stack_model[sp_model-2] = b;
          sp_model--;
        end else err = 1'b1;
      end
      OP_NOT: if (room(1, 0)) stack_model[sp_model-1] = ~stack_model[sp_model-1];
              else err = 1'b1;
      OP_LNOT: if (room(1, 0))
                 stack_model[sp_model-1] = (stack_model[sp_model-1] == 0) ? 16'd1 : 16'd0;
               else err = 1'b1;
      OP_CALL: begin
        if (room(0, 1)) begin
          stack_model[sp_model] = after;
          sp_model++;
          npc = w;
        end else err = 1'b1;
      end
      OP_RET: begin
        if (room(1, 0)) begin
          sp_model--;
          npc = stack_model[sp_model];
        end else err = 1'b1;
      end
      OP_JMP:  npc = w;
      OP_JREL: npc = after + w;
      default: begin
        if ((it.opcode >= OP_JEQ && it.opcode <= OP_JGE) ||
            (it.opcode >= OP_RJEQ && it.opcode <= OP_RJGE)) begin
          if (room(2, 0)) begin
            a = stack_model[sp_model-1];
            b = stack_model[sp_model-2];
            if (compare_holds(it.opcode[2:0] & CMP_MASK[2:0], a, b))
              npc = (it.opcode < OP_JREL) ? w : after + w;
            sp_model -= 2;
          end else err = 1'b1;
        end
      end
    endcase
    pc_model = npc;
    r.next_pc = npc;
    r.top_value = (sp_model != 0) ? stack_model[sp_model-1] : 16'd0;
    r.stack_error = err;
    return r;
  endfunction

  // send one transaction and record its expected result
  task automatic send_instr(input in_t it);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
      @(negedge clk);
    in_data <= it;
    in_valid <= 1'b1;
    pending_results.push_back(execute_instr(it));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic in_t random_fields(input logic [7:0] op);
    in_t it;
    it.opcode = op;
    it.operand_word = 16'($urandom);
    it.second_word = 16'($urandom);
    it.audio_busy = 1'($urandom);
    it.input_lines = 8'($urandom);
    it.time_ms = 16'($urandom);
    it.random_value = 16'($urandom);
    return it;
  endfunction

  task automatic send_op(input logic [7:0] op, input logic [15:0] w);
    in_t it;
    it = random_fields(op);
    it.operand_word = w;
    send_instr(it);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // receiver stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.next_pc, 16'h0000);
      end else begin
        want = pending_results.pop_front();
        if (out_data.next_pc !== want.next_pc)
          report_mismatch("next_pc", out_data.next_pc, want.next_pc);
        if (out_data.play_request !== want.play_request)
          report_mismatch("play_request", 16'(out_data.play_request),
                          16'(want.play_request));
        if (out_data.play_asset !== want.play_asset)
          report_mismatch("play_asset", out_data.play_asset, want.play_asset);
        if (out_data.top_value !== want.top_value)
          report_mismatch("top_value", out_data.top_value, want.top_value);
        if (out_data.stack_error !== want.stack_error)
          report_mismatch("stack_error", 16'(out_data.stack_error),
                          16'(want.stack_error));
      end
    end
  end

  function automatic int i_dummy();
    return 1;
  endfunction

  // underflow on empty stack, extremes, divide by zero, a mix of opcodes, bad indexes
  task automatic test_directed();
    send_op(OP_DROP, 16'h0000);
    send_op(OP_ADD, 16'h0000);
    send_op(OP_PUSH, 16'hFFFF);
    send_op(OP_PUSH, 16'h0000);
    send_op(OP_DIV, 16'h0000);
    send_op(OP_PUSH, 16'hFFFF);
    send_op(OP_MUL, 16'h0000);
    send_op(OP_PUSH, 16'h0001);
    send_op(OP_ADD, 16'h0000);
    send_op(OP_STATUS, 16'h0000);
    send_op(OP_LOAD, 16'h0000);
    send_op(OP_STORN, 16'hFF00);
    send_op(OP_LOADN, 16'h2000);
    send_op(8'hFF, 16'h0000);
    send_op(OP_CALL, 16'h1234);
    send_op(OP_RET, 16'h0000);
    send_op(OP_JREL, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_op(OP_INPUT, 16'h0000);
    send_op(OP_RJEQ + 8'(i_dummy()), 16'h0010);
    send_op(OP_PLAY, 16'h0000);
  endtask

  // overflow: fill the stack past its depth, then empty it
  task automatic test_overflow();
    for (int i = 0; i < DEPTH + 2; i++) send_op(OP_TIME, 16'h0000);
    send_op(OP_DUP, 16'h0000);
    send_op(OP_OVER, 16'h0000);
    send_op(OP_CALL, 16'h0000);
    for (int i = 0; i < DEPTH + 1; i++) send_op(OP_DROP, 16'h0000);
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [7:0] ops [33] = '{OP_STATUS, OP_INPUT, OP_RANDOM, OP_TIME, OP_PLAY, OP_DROP,
      OP_DUP, OP_PUSH, OP_SWAP, OP_ROT, OP_OVER, OP_LOAD, OP_LOADN, OP_STOR, OP_STORN,
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_LNOT, OP_LAND,
      OP_CALL, OP_RET, OP_JMP, OP_JREL, OP_JEQ, OP_JGE, OP_RJEQ, OP_RJGE};
    int k;
    k = $urandom_range(99, 0);
    if (k < 8) return 8'($urandom);
    if (k < 18) return (($urandom & 1) ? OP_JEQ : OP_RJEQ) + 8'($urandom_range(5, 0));
    return ops[$urandom_range(32, 0)];
  endfunction

  // random programs biased toward a mid-depth stack and in-range indexes
  task automatic test_random(input int count);
    in_t it;
    for (int i = 0; i < count; i++) begin
      if (sp_model < 3 && $urandom_range(3, 0) != 0) it = random_fields(OP_PUSH);
      else it = random_fields(pick_opcode());
      if ($urandom_range(3, 0) != 0) begin
        if (it.opcode == OP_PUSH) it.operand_word = 16'($urandom_range(DEPTH + 1, 0));
        it.operand_word[15:8] = 8'($urandom_range(DEPTH, 0));
      end
      if ($urandom_range(7, 0) == 0)
        it.operand_word = ($urandom & 1) ? 16'hFFFF : 16'h0000;
      send_instr(it);
    end
  endtask

  // hold the receiver off while the sender keeps offering
  task automatic test_backpressure();
    hold_off_cycles = 400;
    test_random(30);
    wait_drained();
    test_random(20);
  endtask

  initial begin
    pc_model = '0;
    sp_model = 0;
    foreach (stack_model[i]) stack_model[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_overflow();
    test_random(200);
    send_idle_pct = 88;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    test_random(150);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    test_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_random(50);

    wait_drained();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[stack_bytecode_executor_top.f]
hdl/sbe_pkg.sv
hdl/sbe_stack_mem.sv
hdl/sbe_divider.sv
hdl/stack_bytecode_executor_top.sv
hdl/sbe_checker.sv
dv/stack_bytecode_executor_top_tb.sv
